>>> hw/rtl/buffer_pool_frame_manager_unit_defines.svh
// Assertion macros shared by the buffer pool frame manager RTL.
`ifndef BUFFER_POOL_FRAME_MANAGER_UNIT_DEFINES_SVH
`define BUFFER_POOL_FRAME_MANAGER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BPFM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BPFM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bpfm_pkg.sv
// Types, codes and helper functions of the buffer pool frame manager.
`default_nettype none
package bpfm_pkg;

  localparam logic [2:0] OP_PIN    = 3'd0;
  localparam logic [2:0] OP_UNPIN  = 3'd1;
  localparam logic [2:0] OP_DIRTY  = 3'd2;
  localparam logic [2:0] OP_FORCE  = 3'd3;
  localparam logic [2:0] OP_FLUSH  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_NOT_PIN   = 3'd2;
  localparam logic [2:0] ST_NOT_DIRTY = 3'd3;
  localparam logic [2:0] ST_NO_FRAME  = 3'd4;

  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_LRU   = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;
  localparam logic [1:0] POL_LFU   = 2'd3;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_FRAMES = 1'b1;

  localparam logic [15:0] FIX_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MODN,
    S_WALK,
    S_LOAD,
    S_FCOUNT,
    S_FEMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic        refb;
    logic [15:0] fix;
    logic [31:0] stamp;
    logic [31:0] use_cnt;
    logic [30:0] page;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic dirty;
    logic refb;
    logic fix;
    logic stamp;
    logic use_cnt;
    logic page;
  } wmask_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        hit;
    logic        load;
    logic        wb;
    logic [30:0] wpage;
    logic        last;
  } out_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic out_t mk_out(input logic [2:0] status, input logic [3:0] frame,
                                  input logic hit, input logic load, input logic wb,
                                  input logic [30:0] wpage, input logic last);
    out_t o;
    o.status = status;
    o.frame  = frame;
    o.hit    = hit;
    o.load   = load;
    o.wb     = wb;
    o.wpage  = wb ? wpage : 31'd0;
    o.last   = last;
    mk_out   = o;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/buffer_pool_frame_manager_unit.sv
// Top level of the buffer pool frame manager: sequencer, counters and ports.
`default_nettype none
`include "buffer_pool_frame_manager_unit_defines.svh"
// The block takes one transaction at a time and walks the frame table one
// entry per clock with a single compare unit. A pin that hits or an unpin,
// mark dirty or force page scans for the page and then decides. A pin miss
// that loads an empty frame, or evicts by LRU or LFU, adds a load step. FIFO
// or CLOCK eviction first reduces the start pointer modulo n, with n frames
// in use, and then walks the pointer from there. Flush all first counts the
// dirty frames and then scans again, spread over its write-back results.
// After the last result is taken the block returns to idle, where it accepts
// the next transaction. The table's single index port sets this sequence.
// Input is accepted only when the previous result has been taken.
module buffer_pool_frame_manager_unit #(
  parameter int FRAMES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [30:0] page_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [3:0]       frame,
  output logic             hit,
  output logic             load_request,
  output logic             write_back,
  output logic [30:0]      written_page,
  output logic             last,
  output logic [31:0]      reads_total,
  output logic [31:0]      writes_total,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);

  localparam int IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW  = ((IW > 4) ? IW : 4) + 1;
  localparam int LIM = (FRAMES < 16) ? FRAMES : 16;

  bpfm_pkg::state_t state, state_next;

  logic [1:0]    policy;
  logic [4:0]    fiu;
  logic [2:0]    op_q;
  logic [30:0]   page_q;
  logic [CW-1:0] ix;
  logic          found;
  logic          have_free;
  logic [CW-1:0] free_ix;
  logic          unp;
  logic          have_best;
  logic [CW-1:0] best_ix;
  logic [31:0]   best_key;
  logic [CW-1:0] start;
  logic [3:0]    clock_hand;
  logic [3:0]    fifo_pos;
  logic [31:0]   stamp;
  logic [31:0]   read_count;
  logic [31:0]   write_count;
  logic [CW-1:0] cnt;
  logic [CW-1:0] emitted;
  logic          flush_more;
  bpfm_pkg::out_t out_q;

  bpfm_pkg::entry_t e;
  bpfm_pkg::entry_t w;
  bpfm_pkg::wmask_t m;

  logic [CW-1:0] n_used;
  logic [CW-1:0] fiu_w;
  logic [CW-1:0] ix_inc;
  logic [CW-1:0] ix_wrap;
  logic          ix_end;
  logic          e_match;
  logic          fix_zero;
  logic          qual;
  logic [31:0]   key;
  logic [31:0]   stamp_inc;
  logic [32:0]   wc_sum;
  logic [31:0]   wc_final;
  logic          femit_last;
  logic          op_taken;
  logic          res_more;

  bpfm_frame_table #(.FRAMES(FRAMES), .IW(IW)) u_table (
    .clk   (clk),
    .rst   (rst),
    .idx   (ix[IW-1:0]),
    .wmask (m),
    .wdata (w),
    .rdata (e)
  );

  always_comb begin
    fiu_w = CW'(fiu);
    if (fiu == 5'd0) begin
      n_used = CW'(1);
    end else if (fiu_w > CW'(LIM)) begin
      n_used = CW'(LIM);
    end else begin
      n_used = fiu_w;
    end
  end

  assign ix_inc     = ix + CW'(1);
  assign ix_wrap    = (ix_inc == n_used) ? '0 : ix_inc;
  assign ix_end     = (ix == n_used);
  assign e_match    = e.valid && (e.page == page_q);
  assign fix_zero   = (e.fix == 16'd0);
  assign qual       = e.valid && e.dirty && fix_zero;
  assign key        = (policy == bpfm_pkg::POL_LRU) ? e.stamp : e.use_cnt;
  assign stamp_inc  = bpfm_pkg::sat_inc(stamp);
  assign wc_sum     = {1'b0, write_count} + 33'(cnt);
  assign wc_final   = wc_sum[32] ? 32'hFFFF_FFFF : wc_sum[31:0];
  assign femit_last = ((emitted + CW'(1)) == cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpfm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    m = '0;
    w = e;
    case (state)
      bpfm_pkg::S_IDLE: begin
        if (in_valid) begin
          if (op == bpfm_pkg::OP_FLUSH) begin
            state_next = bpfm_pkg::S_FCOUNT;
          end else if (op < bpfm_pkg::OP_FLUSH) begin
            state_next = bpfm_pkg::S_SCAN;
          end
        end
      end
      bpfm_pkg::S_SCAN: begin
        if (ix_end || e_match) begin
          state_next = bpfm_pkg::S_DECIDE;
        end
      end
      bpfm_pkg::S_DECIDE: begin
        state_next = bpfm_pkg::S_OUT;
        case (op_q)
          bpfm_pkg::OP_PIN: begin
            if (found) begin
              m.fix = 1'b1;
              w.fix = (e.fix == bpfm_pkg::FIX_MAX) ? e.fix : e.fix + 16'd1;
              case (policy)
                bpfm_pkg::POL_LRU: begin
                  m.stamp = 1'b1;
                  w.stamp = stamp_inc;
                end
                bpfm_pkg::POL_CLOCK: begin
                  m.refb = 1'b1;
                  w.refb = 1'b1;
                end
                bpfm_pkg::POL_LFU: begin
                  m.use_cnt = 1'b1;
                  w.use_cnt = bpfm_pkg::sat_inc(e.use_cnt);
                end
                default: begin
                end
              endcase
            end else if (have_free) begin
              state_next = bpfm_pkg::S_LOAD;
            end else if (!unp) begin
              state_next = bpfm_pkg::S_OUT;
            end else if (policy == bpfm_pkg::POL_FIFO || policy == bpfm_pkg::POL_CLOCK) begin
              state_next = bpfm_pkg::S_MODN;
            end else begin
              state_next = bpfm_pkg::S_LOAD;
            end
          end
          bpfm_pkg::OP_UNPIN: begin
            if (found && !fix_zero) begin
              m.fix = 1'b1;
              w.fix = e.fix - 16'd1;
            end
          end
          bpfm_pkg::OP_DIRTY: begin
            if (found) begin
              m.dirty = 1'b1;
              w.dirty = 1'b1;
            end
          end
          bpfm_pkg::OP_FORCE: begin
            if (found && e.dirty) begin
              m.dirty = 1'b1;
              w.dirty = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      bpfm_pkg::S_MODN: begin
        if (start < n_used) begin
          state_next = bpfm_pkg::S_WALK;
        end
      end
      bpfm_pkg::S_WALK: begin
        if (fix_zero && (policy == bpfm_pkg::POL_FIFO || !e.refb)) begin
          state_next = bpfm_pkg::S_LOAD;
        end else if (fix_zero) begin
          m.refb = 1'b1;
          w.refb = 1'b0;
        end
      end
      bpfm_pkg::S_LOAD: begin
        m = '1;
        w.valid   = 1'b1;
        w.dirty   = 1'b0;
        w.refb    = 1'b1;
        w.fix     = 16'd1;
        w.stamp   = stamp_inc;
        w.use_cnt = 32'd1;
        w.page    = page_q;
        state_next = bpfm_pkg::S_OUT;
      end
      bpfm_pkg::S_FCOUNT: begin
        if (ix_end) begin
          state_next = (cnt == '0) ? bpfm_pkg::S_OUT : bpfm_pkg::S_FEMIT;
        end
      end
      bpfm_pkg::S_FEMIT: begin
        if (qual) begin
          m.dirty = 1'b1;
          w.dirty = 1'b0;
          state_next = bpfm_pkg::S_OUT;
        end
      end
      bpfm_pkg::S_OUT: begin
        if (out_ready) begin
          state_next = flush_more ? bpfm_pkg::S_FEMIT : bpfm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bpfm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= bpfm_pkg::POL_FIFO;
      fiu    <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        bpfm_pkg::CFG_POLICY: policy <= cfg_data[1:0];
        bpfm_pkg::CFG_FRAMES: fiu    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hand  <= 4'd0;
      fifo_pos    <= 4'd0;
      stamp       <= 32'd0;
      read_count  <= 32'd0;
      write_count <= 32'd0;
      flush_more  <= 1'b0;
    end else begin
      case (state)
        bpfm_pkg::S_IDLE: begin
          if (in_valid) begin
            op_q       <= op;
            page_q     <= page_number;
            ix         <= '0;
            found      <= 1'b0;
            have_free  <= 1'b0;
            unp        <= 1'b0;
            have_best  <= 1'b0;
            cnt        <= '0;
            emitted    <= '0;
            flush_more <= 1'b0;
          end
        end
        bpfm_pkg::S_SCAN: begin
          if (!ix_end) begin
            if (e_match) begin
              found <= 1'b1;
            end else begin
              if (!e.valid && !have_free) begin
                have_free <= 1'b1;
                free_ix   <= ix;
              end
              if (fix_zero) begin
                unp <= 1'b1;
                if (!have_best || key < best_key) begin
                  have_best <= 1'b1;
                  best_ix   <= ix;
                  best_key  <= key;
                end
              end
              ix <= ix_inc;
            end
          end
        end
        bpfm_pkg::S_DECIDE: begin
          case (op_q)
            bpfm_pkg::OP_PIN: begin
              if (found) begin
                stamp <= stamp_inc;
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_OK, ix[3:0], 1'b1, 1'b0, 1'b0,
                                          31'd0, 1'b1);
              end else if (have_free) begin
                ix <= free_ix;
              end else if (!unp) begin
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_NO_FRAME, 4'd0, 1'b0, 1'b0, 1'b0,
                                          31'd0, 1'b1);
              end else if (policy == bpfm_pkg::POL_FIFO) begin
                start <= CW'(fifo_pos);
              end else if (policy == bpfm_pkg::POL_CLOCK) begin
                start <= CW'(clock_hand);
              end else begin
                ix <= best_ix;
              end
            end
            bpfm_pkg::OP_UNPIN: begin
              if (!found) begin
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_NOT_FOUND, 4'd0, 1'b0, 1'b0, 1'b0,
                                          31'd0, 1'b1);
              end else if (fix_zero) begin
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_NOT_PIN, ix[3:0], 1'b0, 1'b0, 1'b0,
                                          31'd0, 1'b1);
              end else begin
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_OK, ix[3:0], 1'b0, 1'b0, 1'b0,
                                          31'd0, 1'b1);
              end
            end
            bpfm_pkg::OP_DIRTY: begin
              if (!found) begin
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_NOT_FOUND, 4'd0, 1'b0, 1'b0, 1'b0,
                                          31'd0, 1'b1);
              end else begin
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_OK, ix[3:0], 1'b0, 1'b0, 1'b0,
                                          31'd0, 1'b1);
              end
            end
            default: begin
              if (!found) begin
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_NOT_FOUND, 4'd0, 1'b0, 1'b0, 1'b0,
                                          31'd0, 1'b1);
              end else if (!e.dirty) begin
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_NOT_DIRTY, ix[3:0], 1'b0, 1'b0,
                                          1'b0, 31'd0, 1'b1);
              end else begin
                write_count <= bpfm_pkg::sat_inc(write_count);
                out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_OK, ix[3:0], 1'b0, 1'b0, 1'b1,
                                          e.page, 1'b1);
              end
            end
          endcase
        end
        bpfm_pkg::S_MODN: begin
          if (start < n_used) begin
            ix <= start;
          end else begin
            start <= start - n_used;
          end
        end
        bpfm_pkg::S_WALK: begin
          if (fix_zero && (policy == bpfm_pkg::POL_FIFO || !e.refb)) begin
            if (policy == bpfm_pkg::POL_FIFO) begin
              fifo_pos <= ix_wrap[3:0];
            end else begin
              clock_hand <= ix_wrap[3:0];
            end
          end else begin
            ix <= ix_wrap;
          end
        end
        bpfm_pkg::S_LOAD: begin
          stamp      <= stamp_inc;
          read_count <= bpfm_pkg::sat_inc(read_count);
          if (e.valid && e.dirty) begin
            write_count <= bpfm_pkg::sat_inc(write_count);
          end
          out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_OK, ix[3:0], 1'b0, 1'b1,
                                    e.valid && e.dirty, e.page, 1'b1);
        end
        bpfm_pkg::S_FCOUNT: begin
          if (ix_end) begin
            write_count <= wc_final;
            ix          <= '0;
            out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_OK, 4'd0, 1'b0, 1'b0, 1'b0, 31'd0, 1'b1);
          end else begin
            if (qual) begin
              cnt <= cnt + CW'(1);
            end
            ix <= ix_inc;
          end
        end
        bpfm_pkg::S_FEMIT: begin
          ix <= ix_inc;
          if (qual) begin
            emitted    <= emitted + CW'(1);
            flush_more <= !femit_last;
            out_q <= bpfm_pkg::mk_out(bpfm_pkg::ST_OK, ix[3:0], 1'b0, 1'b0, 1'b1, e.page,
                                      femit_last);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready     = (state == bpfm_pkg::S_IDLE);
  assign out_valid    = (state == bpfm_pkg::S_OUT);
  assign status       = out_q.status;
  assign frame        = out_q.frame;
  assign hit          = out_q.hit;
  assign load_request = out_q.load;
  assign write_back   = out_q.wb;
  assign written_page = out_q.wpage;
  assign last         = out_q.last;
  assign reads_total  = read_count;
  assign writes_total = write_count;

  assign op_taken = in_valid && in_ready && (op <= bpfm_pkg::OP_FLUSH);
  assign res_more = out_valid && out_ready && !last;

  `BPFM_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input taken while a result waits")
  `BPFM_ASSERT_NEXT(a_busy_after_op, op_taken, !in_ready, "block idle after an operation")
  `BPFM_ASSERT_NEXT(a_flush_continues, res_more, !in_ready, "idle before the final result")
  `BPFM_ASSERT_NOW(a_wb_ok, out_valid && write_back, status == bpfm_pkg::ST_OK, "bad wb status")

endmodule
`default_nettype wire

>>> hw/rtl/bpfm_frame_table.sv
// Per-frame state table with one shared read and write index.
`default_nettype none
module bpfm_frame_table #(
  parameter int FRAMES = 16,
  parameter int IW     = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IW-1:0]    idx,
  input  wire bpfm_pkg::wmask_t wmask,
  input  wire bpfm_pkg::entry_t wdata,
  output bpfm_pkg::entry_t      rdata
);

  logic        valid_a [FRAMES];
  logic        dirty_a [FRAMES];
  logic        refb_a  [FRAMES];
  logic [15:0] fix_a   [FRAMES];
  logic [31:0] stamp_a [FRAMES];
  logic [31:0] use_a   [FRAMES];
  logic [30:0] page_a  [FRAMES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) begin
        valid_a[i] <= 1'b0;
        dirty_a[i] <= 1'b0;
        refb_a[i]  <= 1'b0;
        fix_a[i]   <= 16'd0;
        stamp_a[i] <= 32'd0;
        use_a[i]   <= 32'd0;
      end
    end else begin
      if (wmask.valid)   valid_a[idx] <= wdata.valid;
      if (wmask.dirty)   dirty_a[idx] <= wdata.dirty;
      if (wmask.refb)    refb_a[idx]  <= wdata.refb;
      if (wmask.fix)     fix_a[idx]   <= wdata.fix;
      if (wmask.stamp)   stamp_a[idx] <= wdata.stamp;
      if (wmask.use_cnt) use_a[idx]   <= wdata.use_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (wmask.page) page_a[idx] <= wdata.page;
  end

  always_comb begin
    rdata.valid   = valid_a[idx];
    rdata.dirty   = dirty_a[idx];
    rdata.refb    = refb_a[idx];
    rdata.fix     = fix_a[idx];
    rdata.stamp   = stamp_a[idx];
    rdata.use_cnt = use_a[idx];
    rdata.page    = page_a[idx];
  end

endmodule
`default_nettype wire
